/* hdl/nearest_tool_pocket_selector_core_assert.svh */
// Assertion macros used by the checker file of this block.
// Each macro gives a labeled concurrent assertion that is held off during reset.
`ifndef NEAREST_TOOL_POCKET_SELECTOR_CORE_ASSERT_SVH
`define NEAREST_TOOL_POCKET_SELECTOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NTPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hdl/ntps_pkg.sv */
package ntps_pkg;

	// Magazine size and the widths that follow from it.
	localparam int POCKETS = 8;
	localparam int PIDX_W = (POCKETS > 1) ? $clog2(POCKETS) : 1;
	localparam int CNT_W = $clog2(POCKETS + 1);

	// Field widths.
	localparam int OP_W = 2;
	localparam int SLOT_W = 3;
	localparam int TOOL_W = 8;
	localparam int LIFE_W = 16;
	localparam int CFG_W = 4;
	localparam int POS_OUT_W = 3;
	localparam int STEP_W = 3;
	localparam int COST_W = 32;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;

	localparam int MIN_POCKETS = 2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_REQUEST = 2'd1,
		OP_EOP     = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	// Control from the sequencer to the pocket store.
	typedef struct packed {
		logic              load_en;
		logic [PIDX_W-1:0] load_idx;
		logic [TOOL_W-1:0] load_tool;
		logic [LIFE_W-1:0] load_life;
		logic              mark_en;
		logic [PIDX_W-1:0] mark_idx;
		logic              wear_en;
		logic [PIDX_W-1:0] rd_idx;
	} store_ctl_t;

	// Result of the shared distance and compare unit.
	typedef struct packed {
		logic              better;
		logic [PIDX_W-1:0] gap;
	} cmp_res_t;

endpackage

/* hdl/ntps_pocket_store.sv */
module ntps_pocket_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ntps_pkg::store_ctl_t           ctl,
	output logic [ntps_pkg::TOOL_W-1:0]    rd_tool,
	output logic [ntps_pkg::LIFE_W-1:0]    rd_life
);

	logic [ntps_pkg::TOOL_W-1:0] tool_q [ntps_pkg::POCKETS];
	logic [ntps_pkg::LIFE_W-1:0] life_q [ntps_pkg::POCKETS];
	logic [ntps_pkg::POCKETS-1:0] mark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ntps_pkg::POCKETS; i++) begin
				tool_q[i] <= '0;
				life_q[i] <= '0;
			end
			mark_q <= '0;
		end else begin
			if (ctl.load_en) begin
				tool_q[ctl.load_idx] <= ctl.load_tool;
				life_q[ctl.load_idx] <= ctl.load_life;
			end
			if (ctl.mark_en) begin
				mark_q[ctl.mark_idx] <= 1'b1;
			end
			// One pocket per cycle loses a use if it was marked, then its mark clears.
			if (ctl.wear_en) begin
				if (mark_q[ctl.rd_idx] && (life_q[ctl.rd_idx] != '0)) begin
					life_q[ctl.rd_idx] <= life_q[ctl.rd_idx] - ntps_pkg::LIFE_W'(1);
				end
				mark_q[ctl.rd_idx] <= 1'b0;
			end
		end
	end

	assign rd_tool = tool_q[ctl.rd_idx];
	assign rd_life = life_q[ctl.rd_idx];

endmodule

/* hdl/ntps_dist_unit.sv */
module ntps_dist_unit (
	input  logic [ntps_pkg::PIDX_W-1:0] pos,
	input  logic [ntps_pkg::PIDX_W-1:0] idx,
	input  logic [ntps_pkg::CNT_W-1:0]  n_act,
	input  logic [ntps_pkg::TOOL_W-1:0] cand_tool,
	input  logic [ntps_pkg::LIFE_W-1:0] cand_life,
	input  logic [ntps_pkg::TOOL_W-1:0] want_tool,
	input  logic                        have_best,
	input  logic [ntps_pkg::PIDX_W-1:0] best_dist,
	output ntps_pkg::cmp_res_t          res
);

	logic [ntps_pkg::PIDX_W-1:0] d;
	logic [ntps_pkg::CNT_W-1:0]  d_ext;
	logic [ntps_pkg::CNT_W-1:0]  wrap;
	logic                        usable;

	always_comb begin
		d     = (pos > idx) ? (pos - idx) : (idx - pos);
		d_ext = ntps_pkg::CNT_W'(d);
		wrap  = n_act - d_ext;
		// The wrapped way round counts only when the direct span lies on the circle.
		if ((d_ext < n_act) && (wrap < d_ext)) begin
			res.gap = ntps_pkg::PIDX_W'(wrap);
		end else begin
			res.gap = d;
		end
		usable     = (cand_tool == want_tool) && (cand_life != '0);
		res.better = usable && (!have_best || (res.gap < best_dist));
	end

endmodule

/* hdl/nearest_tool_pocket_selector_core.sv */
// Nearest tool pocket selector. Every accepted word produces exactly one result word.
// A load word (tuser 0) writes a pocket's tool and life, a request word (tuser 1)
// scans pockets 0 to n-1, where n is pockets_in_use held between 2 and the
// magazine size, and picks the usable pocket holding the tool that lies nearest
// the current position around the circle, the lowest pocket winning a tie. A hit
// moves the position there, adds the distance to a saturating cost and marks the
// pocket used; a miss changes nothing and reports found low. An end-of-product word
// (tuser 2) takes one use off every marked pocket and clears the marks, and a
// restart word (tuser 3) zeroes position and cost. The block works on one word at
// a time with a single distance and compare unit stepped by a small sequencer:
// a request steps through the active pockets one at a time, an end of product
// wears every pocket of the magazine in turn, and load and restart go straight
// to the result stage. s_tready is high only while the sequencer is
// idle. The result sits in an output register, so a new word is accepted while an
// earlier result still waits on m_tready. Write pockets_in_use only while idle.
module nearest_tool_pocket_selector_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// pocket_slot [2:0], tool_id [10:3], life_value [26:11], zero above
	input  logic [ntps_pkg::S_TDATA_W-1:0]    s_tdata,
	// op [1:0]
	input  logic [ntps_pkg::OP_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// chosen_pocket [2:0], step_distance [5:3], total_cost [37:6], zero above
	output logic [ntps_pkg::M_TDATA_W-1:0]    m_tdata,
	// found [0]
	output logic [0:0]                        m_tuser,
	input  logic                              cfg_wr_en,
	input  logic [ntps_pkg::CFG_W-1:0]        cfg_wr_data
);

	localparam int PW = ntps_pkg::PIDX_W;
	localparam int CW = ntps_pkg::CNT_W;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_WEAR = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [ntps_pkg::CFG_W-1:0]     cfg_q;
	logic [CW-1:0]                  n_act;
	logic [PW-1:0]                  idx_q;
	logic [PW-1:0]                  pos_q;
	logic [ntps_pkg::COST_W-1:0]    cost_q;
	logic [ntps_pkg::TOOL_W-1:0]    want_q;
	logic                           found_q;
	logic [PW-1:0]                  best_q;
	logic [PW-1:0]                  best_d_q;
	logic                           m_tvalid_q;
	logic [ntps_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                           m_found_q;

	ntps_pkg::store_ctl_t           ctl;
	ntps_pkg::cmp_res_t             cmp;
	logic [ntps_pkg::TOOL_W-1:0]    rd_tool;
	logic [ntps_pkg::LIFE_W-1:0]    rd_life;

	// Unpacked input fields.
	logic [ntps_pkg::SLOT_W-1:0]    in_slot;
	logic [ntps_pkg::TOOL_W-1:0]    in_tool;
	logic [ntps_pkg::LIFE_W-1:0]    in_life;
	ntps_pkg::op_t                  in_op;

	logic                           accept;
	logic                           out_free;
	logic                           done_fire;
	logic                           scan_last;
	logic                           wear_last;
	logic [ntps_pkg::COST_W:0]      cost_sum;
	logic [ntps_pkg::COST_W-1:0]    cost_next;
	logic [PW-1:0]                  pos_next;

	assign in_slot = s_tdata[ntps_pkg::SLOT_W-1:0];
	assign in_tool = s_tdata[ntps_pkg::SLOT_W +: ntps_pkg::TOOL_W];
	assign in_life = s_tdata[ntps_pkg::SLOT_W + ntps_pkg::TOOL_W +: ntps_pkg::LIFE_W];
	assign in_op   = ntps_pkg::op_t'(s_tuser);

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign done_fire = (state_q == ST_DONE) && out_free;

	// The active pocket count is the register held inside [2, magazine size].
	always_comb begin
		if (32'(cfg_q) < ntps_pkg::MIN_POCKETS) begin
			n_act = CW'(ntps_pkg::MIN_POCKETS);
		end else if (32'(cfg_q) > ntps_pkg::POCKETS) begin
			n_act = CW'(ntps_pkg::POCKETS);
		end else begin
			n_act = CW'(cfg_q);
		end
	end

	assign scan_last = ((CW'(idx_q) + CW'(1)) == n_act);
	assign wear_last = (idx_q == PW'(ntps_pkg::POCKETS - 1));

	// Saturating cost update and new position, applied only on a hit.
	assign cost_sum  = {1'b0, cost_q} + (ntps_pkg::COST_W + 1)'(best_d_q);
	assign cost_next = found_q ? (cost_sum[ntps_pkg::COST_W] ? '1 :
		cost_sum[ntps_pkg::COST_W-1:0]) : cost_q;
	assign pos_next  = found_q ? best_q : pos_q;

	always_comb begin
		ctl.load_en   = accept && (in_op == ntps_pkg::OP_LOAD) &&
			(32'(in_slot) < ntps_pkg::POCKETS);
		ctl.load_idx  = PW'(in_slot);
		ctl.load_tool = in_tool;
		ctl.load_life = in_life;
		ctl.mark_en   = (state_q == ST_DONE) && out_free && found_q;
		ctl.mark_idx  = best_q;
		ctl.wear_en   = (state_q == ST_WEAR);
		ctl.rd_idx    = idx_q;
	end

	ntps_pocket_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_tool (rd_tool),
		.rd_life (rd_life)
	);

	ntps_dist_unit u_dist (
		.pos       (pos_q),
		.idx       (idx_q),
		.n_act     (n_act),
		.cand_tool (rd_tool),
		.cand_life (rd_life),
		.want_tool (want_q),
		.have_best (found_q),
		.best_dist (best_d_q),
		.res       (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ntps_pkg::CFG_W'(8);
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	// Sequencer and machine state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			pos_q      <= '0;
			cost_q     <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			best_d_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q    <= '0;
						found_q  <= 1'b0;
						best_d_q <= '0;
						unique case (in_op)
							ntps_pkg::OP_REQUEST: state_q <= ST_SCAN;
							ntps_pkg::OP_EOP:     state_q <= ST_WEAR;
							ntps_pkg::OP_RESTART: begin
								pos_q   <= '0;
								cost_q  <= '0;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					if (cmp.better) begin
						found_q  <= 1'b1;
						best_q   <= idx_q;
						best_d_q <= cmp.gap;
					end
					idx_q <= idx_q + PW'(1);
					if (scan_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_WEAR: begin
					idx_q <= idx_q + PW'(1);
					if (wear_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						pos_q      <= pos_next;
						cost_q     <= cost_next;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The output word is registered when the sequencer finishes and stays offered until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Payload registers of the output and the requested tool need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			want_q <= in_tool;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_found_q <= found_q;
			m_tdata_q <= ntps_pkg::M_TDATA_W'({
				cost_next,
				ntps_pkg::STEP_W'(found_q ? best_d_q : '0),
				ntps_pkg::POS_OUT_W'(pos_next)
			});
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_found_q;

endmodule

/* hdl/ntps_checker.sv */
`include "nearest_tool_pocket_selector_core_assert.svh"

module ntps_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ntps_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [0:0]                     m_tuser
);

	// A result that is not taken stays offered with the same data.
	`NTPS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Every word passes through a sequencer state after idle, so the input closes right after acceptance.
	`NTPS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// A result without a hit never reports a move.
	`NTPS_ASSERT_NOW(a_miss_no_move, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[5:3] == 3'd0)

endmodule

bind nearest_tool_pocket_selector_core ntps_checker u_ntps_checker (.*);

/* verif/tb_nearest_tool_pocket_selector_core.sv */
`timescale 1ns / 100ps

module tb_nearest_tool_pocket_selector_core;

	// One word into the magazine: what to do and the fields it carries.
	// Fields that an operation does not use still travel, with random content in the random part.
	typedef struct packed {
		ntps_pkg::op_t               op;
		logic [ntps_pkg::SLOT_W-1:0] slot;
		logic [ntps_pkg::TOOL_W-1:0] tool;
		logic [ntps_pkg::LIFE_W-1:0] life;
	} tool_word_t;

	// One result word: the pick made by a request, or the magazine position
	// and running cost after any other operation.
	typedef struct packed {
		logic                           found;
		logic [ntps_pkg::POS_OUT_W-1:0] pocket;
		logic [ntps_pkg::STEP_W-1:0]    step;
		logic [ntps_pkg::COST_W-1:0]    cost;
	} pick_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [ntps_pkg::S_TDATA_W-1:0] s_tdata;
	logic [ntps_pkg::OP_W-1:0]      s_tuser;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [ntps_pkg::M_TDATA_W-1:0] m_tdata;
	logic [0:0]                     m_tuser;
	logic                           cfg_wr_en = 1'b0;
	logic [ntps_pkg::CFG_W-1:0]     cfg_wr_data = '0;

	// Word currently offered on the slave side, and whether it was taken at
	// the last rising edge. The driver reads the flag at the falling edge.
	tool_word_t cur_word = '0;
	logic       word_taken = 1'b0;

	// Words waiting to be sent, and the picks the magazine should return, oldest first.
	tool_word_t tool_words[$];
	pick_t      predicted_picks[$];

	// Percentage of cycles in which the sender holds back and the receiver stalls.
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;

	// Our own copy of the magazine: pockets, marks, position, cost and the
	// pocket count register as last written.
	logic [ntps_pkg::TOOL_W-1:0] mag_tool [ntps_pkg::POCKETS];
	logic [ntps_pkg::LIFE_W-1:0] mag_life [ntps_pkg::POCKETS];
	logic                        mag_mark [ntps_pkg::POCKETS];
	int unsigned                 mag_pos;
	logic [ntps_pkg::COST_W-1:0] mag_cost;
	logic [ntps_pkg::CFG_W-1:0]  mag_count_reg;

	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned hit_count = 0;
	int unsigned miss_count = 0;
	int unsigned eop_count = 0;
	int unsigned restart_count = 0;
	int unsigned settings_used = 0;

	// Pocket count settings for the random part, both saturation ends included.
	int unsigned count_plan [12] = '{8, 5, 0, 15, 3, 1, 9, 6, 2, 12, 7, 4};

	nearest_tool_pocket_selector_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Slave tdata holds pocket_slot, tool_id and life_value from the lowest bit up.
	assign s_tdata = {{(ntps_pkg::S_TDATA_W - ntps_pkg::SLOT_W - ntps_pkg::TOOL_W -
		ntps_pkg::LIFE_W){1'b0}}, cur_word.life, cur_word.tool, cur_word.slot};
	assign s_tuser = cur_word.op;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Work out what the magazine returns for one word and update our copy of it.
	// A request scans only the active pockets, takes the nearest usable one around
	// the circle and keeps the lower index on a tie. The way round the circle counts
	// only when the plain index difference lies below the active pocket count.
	function automatic pick_t apply_word(input tool_word_t w);
		pick_t       res;
		int unsigned span;
		int unsigned gap;
		int unsigned best;
		int unsigned best_dist;
		logic        hit;

		hit = 1'b0;
		best = 0;
		best_dist = 0;
		case (w.op)
			ntps_pkg::OP_LOAD: begin
				// Loading keeps the pocket's used mark.
				mag_tool[w.slot] = w.tool;
				mag_life[w.slot] = w.life;
			end
			ntps_pkg::OP_REQUEST: begin
				span = 32'(mag_count_reg);
				if (span < ntps_pkg::MIN_POCKETS)
					span = ntps_pkg::MIN_POCKETS;
				if (span > ntps_pkg::POCKETS)
					span = ntps_pkg::POCKETS;
				for (int i = 0; i < span; i++) begin
					if (mag_tool[i] == w.tool && mag_life[i] != 0) begin
						gap = (mag_pos > i) ? mag_pos - i : i - mag_pos;
						if (gap < span && span - gap < gap)
							gap = span - gap;
						if (!hit || gap < best_dist) begin
							hit = 1'b1;
							best = i;
							best_dist = gap;
						end
					end
				end
				// A miss leaves everything as it was.
				if (hit) begin
					mag_pos = best;
					if (mag_cost > 32'hFFFF_FFFF - best_dist)
						mag_cost = '1;
					else
						mag_cost = mag_cost + best_dist;
					mag_mark[best] = 1'b1;
				end
			end
			ntps_pkg::OP_EOP: begin
				// A marked pocket reloaded with no life left stays at zero.
				for (int i = 0; i < ntps_pkg::POCKETS; i++) begin
					if (mag_mark[i] && mag_life[i] != 0)
						mag_life[i] = mag_life[i] - 1'b1;
					mag_mark[i] = 1'b0;
				end
			end
			default: begin
				mag_pos = 0;
				mag_cost = '0;
			end
		endcase
		res.found = hit;
		res.pocket = ntps_pkg::POS_OUT_W'(mag_pos);
		res.step = hit ? ntps_pkg::STEP_W'(best_dist) : '0;
		res.cost = mag_cost;
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
	endtask

	// Driver. A new word goes out only once the previous one was taken, so
	// tvalid never drops while a word is on offer.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || word_taken)) begin
			if (tool_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				cur_word <= tool_words.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Monitor. Results are checked against the oldest prediction before the
	// word taken at this same edge is predicted.
	always @(posedge clk) begin : monitor
		pick_t want;
		pick_t got;

		if (arst_n) begin
			word_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got.found = m_tuser[0];
				got.pocket = m_tdata[ntps_pkg::POS_OUT_W-1:0];
				got.step = m_tdata[ntps_pkg::POS_OUT_W +: ntps_pkg::STEP_W];
				got.cost = m_tdata[ntps_pkg::POS_OUT_W + ntps_pkg::STEP_W +:
					ntps_pkg::COST_W];
				if (predicted_picks.size() == 0) begin
					flag_mismatch("result word with none pending, cost", got.cost, 0);
				end else begin
					want = predicted_picks.pop_front();
					if (got.found !== want.found)
						flag_mismatch("found", 32'(got.found), 32'(want.found));
					if (got.pocket !== want.pocket)
						flag_mismatch("chosen_pocket", 32'(got.pocket), 32'(want.pocket));
					if (got.step !== want.step)
						flag_mismatch("step_distance", 32'(got.step), 32'(want.step));
					if (got.cost !== want.cost)
						flag_mismatch("total_cost", got.cost, want.cost);
				end
			end
			if (s_tvalid && s_tready) begin
				want = apply_word(cur_word);
				predicted_picks.insert(predicted_picks.size(), want);
				words_sent++;
				if (cur_word.op == ntps_pkg::OP_REQUEST) begin
					if (want.found)
						hit_count++;
					else
						miss_count++;
				end
				if (cur_word.op == ntps_pkg::OP_EOP)
					eop_count++;
				if (cur_word.op == ntps_pkg::OP_RESTART)
					restart_count++;
			end
		end
	end

	task automatic add_word(input ntps_pkg::op_t op, input int unsigned slot,
		input int unsigned tool, input int unsigned life);
		tool_word_t w;

		w.op = op;
		w.slot = ntps_pkg::SLOT_W'(slot);
		w.tool = ntps_pkg::TOOL_W'(tool);
		w.life = ntps_pkg::LIFE_W'(life);
		tool_words.insert(tool_words.size(), w);
	endtask

	// Wait until every word was sent and every result came back. Ends on a
	// rising edge so that the queue is refilled away from the driver's edge.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (tool_words.size() != 0 || s_tvalid || predicted_picks.size() != 0);
	endtask

	// Written only while the magazine is idle, so our copy can change at once.
	task automatic write_pocket_count(input int unsigned value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ntps_pkg::CFG_W'(value);
		mag_count_reg = ntps_pkg::CFG_W'(value);
		settings_used++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Tools mostly come from a small set so that requests find loaded pockets;
	// the set holds ids with every bit low and every bit high.
	function automatic logic [ntps_pkg::TOOL_W-1:0] pick_tool();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'h5A;
			2: return 8'hA5;
			3: return 8'hFF;
			default: return ntps_pkg::TOOL_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Random word. Loads mostly fill active pockets with short lives so that
	// wear-out and misses come up often; a few lives span the whole range.
	function automatic tool_word_t random_word(input int unsigned span);
		tool_word_t  w;
		int unsigned roll;

		w.slot = ntps_pkg::SLOT_W'($urandom_range(0, ntps_pkg::POCKETS - 1));
		w.tool = ntps_pkg::TOOL_W'($urandom_range(0, 255));
		w.life = ntps_pkg::LIFE_W'($urandom_range(0, 65535));
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			w.op = ntps_pkg::OP_LOAD;
			if ($urandom_range(0, 99) < 80)
				w.slot = ntps_pkg::SLOT_W'($urandom_range(0, span - 1));
			w.tool = pick_tool();
			roll = $urandom_range(0, 99);
			if (roll < 60)
				w.life = ntps_pkg::LIFE_W'($urandom_range(0, 3));
			else if (roll < 85)
				w.life = ntps_pkg::LIFE_W'($urandom_range(0, 40));
		end else if (roll < 80) begin
			w.op = ntps_pkg::OP_REQUEST;
			if ($urandom_range(0, 99) < 90)
				w.tool = pick_tool();
		end else if (roll < 95) begin
			w.op = ntps_pkg::OP_EOP;
		end else begin
			w.op = ntps_pkg::OP_RESTART;
		end
		return w;
	endfunction

	initial begin : stimulus
		int unsigned span;

		for (int i = 0; i < ntps_pkg::POCKETS; i++) begin
			mag_tool[i] = '0;
			mag_life[i] = '0;
			mag_mark[i] = 1'b0;
		end
		mag_pos = 0;
		mag_cost = '0;
		mag_count_reg = ntps_pkg::CFG_W'(ntps_pkg::POCKETS);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the full magazine.
		tx_idle_pct = 14;
		rx_idle_pct = 87;
		write_pocket_count(8);
		add_word(ntps_pkg::OP_REQUEST, 0, 8'h00, 0);  // Tool 0 matches every pocket, but no life.
		add_word(ntps_pkg::OP_LOAD, 0, 8'hFF, 16'hFFFF);
		add_word(ntps_pkg::OP_LOAD, 7, 8'hFF, 1);
		add_word(ntps_pkg::OP_LOAD, 3, 8'h00, 0);
		add_word(ntps_pkg::OP_REQUEST, 0, 8'h00, 0);  // Still a miss.
		add_word(ntps_pkg::OP_REQUEST, 0, 8'hFF, 0);  // Pocket 0 is right here.
		add_word(ntps_pkg::OP_LOAD, 6, 8'h09, 2);
		add_word(ntps_pkg::OP_LOAD, 2, 8'h09, 1);
		add_word(ntps_pkg::OP_REQUEST, 0, 8'h09, 0);  // Pockets 2 and 6 tie, 2 wins.
		add_word(ntps_pkg::OP_REQUEST, 0, 8'hFF, 0);  // Back to 0 rather than round to 7.
		add_word(ntps_pkg::OP_LOAD, 5, 8'd77, 3);
		add_word(ntps_pkg::OP_REQUEST, 0, 8'd77, 0);
		add_word(ntps_pkg::OP_EOP, 0, 0, 0);          // Pocket 2 wears out.
		add_word(ntps_pkg::OP_REQUEST, 0, 8'h09, 0);  // Only pocket 6 is left.
		add_word(ntps_pkg::OP_LOAD, 6, 8'h09, 0);     // Marked pocket reloaded empty.
		add_word(ntps_pkg::OP_EOP, 0, 0, 0);
		add_word(ntps_pkg::OP_REQUEST, 0, 8'h09, 0);
		add_word(ntps_pkg::OP_RESTART, 0, 0, 0);
		add_word(ntps_pkg::OP_LOAD, 7, 8'd128, 5);
		add_word(ntps_pkg::OP_REQUEST, 0, 8'd128, 0); // Wraps around to pocket 7.
		wait_idle();

		// Shrink the circle to two pockets while the position sits at 7.
		write_pocket_count(2);
		add_word(ntps_pkg::OP_REQUEST, 0, 8'hFF, 0);
		add_word(ntps_pkg::OP_LOAD, 1, 8'hFF, 1);
		add_word(ntps_pkg::OP_REQUEST, 0, 8'hFF, 0);
		add_word(ntps_pkg::OP_REQUEST, 0, 8'd128, 0); // Pocket 7 is outside the circle now.
		add_word(ntps_pkg::OP_RESTART, 0, 0, 0);
		wait_idle();

		// Random part: one pocket count per phase, each phase in three bursts
		// with the sender holding off between them until all results are in.
		for (int p = 0; p < 12; p++) begin
			if (p < 4) begin
				tx_idle_pct = 14;
				rx_idle_pct = 87;
			end else if (p < 8) begin
				tx_idle_pct = 87;
				rx_idle_pct = 14;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_pocket_count(count_plan[p]);
			span = count_plan[p];
			if (span < ntps_pkg::MIN_POCKETS)
				span = ntps_pkg::MIN_POCKETS;
			if (span > ntps_pkg::POCKETS)
				span = ntps_pkg::POCKETS;
			for (int b = 0; b < 3; b++) begin
				for (int k = 0; k < 45; k++)
					tool_words.insert(tool_words.size(), random_word(span));
				wait_idle();
			end
		end

		// Let the block settle so that a stray result would still be caught.
		repeat (20) @(posedge clk);
		if (predicted_picks.size() != 0)
			flag_mismatch("results never delivered", predicted_picks.size(), 0);

		$display("Sent %0d words: %0d request hits, %0d misses, %0d ends of product, %0d restarts.",
			words_sent, hit_count, miss_count, eop_count, restart_count);
		$display("Pocket count register written %0d times, %0d field mismatches.",
			settings_used, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Guard against a hung handshake; a correct run needs a small part of this.
	initial begin
		#2000000;
		$display("Timed out with %0d words unsent and %0d results outstanding.",
			tool_words.size(), predicted_picks.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
